FILE: src/dhcp_lease_responder_macros.svh
// Assertion helpers used by the checker file dlr_checker.sv.
`ifndef DHCP_LEASE_RESPONDER_MACROS_SVH
`define DHCP_LEASE_RESPONDER_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define DLR_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("%m: label failed");

// Antecedent in one cycle implies consequent in the same cycle.
`define DLR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: label failed");

// Antecedent in one cycle implies consequent in the next cycle.
`define DLR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: label failed");

`endif

FILE: src/dlr_pkg.sv
package dlr_pkg;

	localparam int LEASE_SLOTS = 4;
	localparam int SLOT_IW     = (LEASE_SLOTS > 1) ? $clog2(LEASE_SLOTS) : 1;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_SERVER_ADDRESS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE      = 1'd1;

	localparam logic [31:0] SERVER_RESET  = 32'hC0A8_0100;
	localparam logic [31:0] POOL_RESET    = 32'hC0A8_0101;
	localparam logic [31:0] PROBE_ADDRESS = 32'hC0A8_0101;

	localparam logic [7:0] KIND_DISCOVER = 8'd1;
	localparam logic [7:0] KIND_REQUEST  = 8'd3;

	localparam logic [1:0] REPLY_OFFER = 2'd0;
	localparam logic [1:0] REPLY_ACK   = 2'd1;
	localparam logic [1:0] REPLY_NAK   = 2'd2;

	// Controller to datapath.
	typedef struct packed {
		logic load;    // capture the incoming word, restart the scan
		logic rd;      // read table entry at the scan pointer
		logic cmp;     // compare the entry just read, advance pointer
		logic commit;  // decide the reply, update table, load output
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic needs_scan;
		logic scan_last;
		logic out_free;
	} stat_t;

endpackage

FILE: src/dlr_if.sv
interface dlr_msg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  msg_kind;
	logic [63:0] hw_addr_high;
	logic [63:0] hw_addr_low;
	logic        has_sid;
	logic [31:0] sid_value;
	logic        has_req_ip;
	logic [31:0] req_ip_value;
	logic        probe_mode;

	modport source (
		output valid, msg_kind, hw_addr_high, hw_addr_low, has_sid, sid_value,
		       has_req_ip, req_ip_value, probe_mode,
		input  ready
	);
	modport sink (
		input  valid, msg_kind, hw_addr_high, hw_addr_low, has_sid, sid_value,
		       has_req_ip, req_ip_value, probe_mode,
		output ready
	);
endinterface

interface dlr_reply_if;
	logic        valid;
	logic        ready;
	logic [1:0]  reply_kind;
	logic [31:0] client_address;
	logic        lease_time_included;

	modport source (
		output valid, reply_kind, client_address, lease_time_included,
		input  ready
	);
	modport sink (
		input  valid, reply_kind, client_address, lease_time_included,
		output ready
	);
endinterface

FILE: src/dlr_ctrl.sv
module dlr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  dlr_pkg::stat_t stat,
	output dlr_pkg::cmd_t  cmd
);
	import dlr_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_READ,
		S_COMPARE,
		S_COMMIT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					state_q <= stat.needs_scan ? S_READ : S_COMMIT;
				end
				S_READ: begin
					state_q <= S_COMPARE;
				end
				S_COMPARE: begin
					state_q <= stat.scan_last ? S_COMMIT : S_READ;
				end
				S_COMMIT: begin
					if (stat.out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == S_IDLE) && in_valid;
		cmd.rd     = (state_q == S_READ);
		cmd.cmp    = (state_q == S_COMPARE);
		cmd.commit = (state_q == S_COMMIT) && stat.out_free;
	end

endmodule

FILE: src/dlr_datapath.sv
module dlr_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_we,
	input  logic [dlr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dlr_pkg::CFG_DATA_W-1:0] cfg_data,
	// message payload
	input  logic [7:0]                     msg_kind,
	input  logic [63:0]                    hw_addr_high,
	input  logic [63:0]                    hw_addr_low,
	input  logic                           has_sid,
	input  logic [31:0]                    sid_value,
	input  logic                           has_req_ip,
	input  logic [31:0]                    req_ip_value,
	input  logic                           probe_mode,
	// reply
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     reply_kind,
	output logic [31:0]                    client_address,
	output logic                           lease_time_included,
	// control
	input  dlr_pkg::cmd_t                  cmd,
	output dlr_pkg::stat_t                 stat
);
	import dlr_pkg::*;

	logic [31:0] server_q;
	logic [31:0] pool_q;

	// captured message
	logic [7:0]   kind_q;
	logic [127:0] hw_q;
	logic         has_sid_q;
	logic [31:0]  sid_q;
	logic         has_req_q;
	logic [31:0]  req_q;
	logic         probe_q;

	// lease table: used flags in flops, addresses in memory
	logic [LEASE_SLOTS-1:0] used_q;
	logic [127:0]           table_mem [LEASE_SLOTS];
	logic [127:0]           rd_data_q;

	logic [SLOT_IW-1:0] cnt_q;
	logic               match_q;
	logic [SLOT_IW-1:0] match_idx_q;
	logic               free_q;
	logic [SLOT_IW-1:0] free_idx_q;

	logic         out_valid_q;
	logic [1:0]   reply_kind_q;
	logic [31:0]  client_address_q;

	logic               is_disc;
	logic               is_req;
	logic               hit;
	logic [SLOT_IW-1:0] slot_sel;
	logic [31:0]        slot_ip;
	logic               req_ok;
	logic               do_alloc;
	logic [1:0]         next_kind;
	logic [31:0]        next_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_q <= SERVER_RESET;
			pool_q   <= POOL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SERVER_ADDRESS: server_q <= cfg_data[31:0];
				CFG_POOL_BASE:      pool_q   <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q    <= msg_kind;
			hw_q      <= {hw_addr_high, hw_addr_low};
			has_sid_q <= has_sid;
			sid_q     <= sid_value;
			has_req_q <= has_req_ip;
			req_q     <= req_ip_value;
			probe_q   <= probe_mode;
		end
	end

	assign is_disc = (kind_q == KIND_DISCOVER);
	assign is_req  = (kind_q == KIND_REQUEST);
	assign hit     = used_q[cnt_q] && (rd_data_q == hw_q);

	// scan pointer and first-match / first-free trackers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			match_q     <= 1'b0;
			match_idx_q <= '0;
			free_q      <= 1'b0;
			free_idx_q  <= '0;
		end else if (cmd.load) begin
			cnt_q   <= '0;
			match_q <= 1'b0;
			free_q  <= 1'b0;
		end else if (cmd.cmp) begin
			cnt_q <= cnt_q + SLOT_IW'(1);
			if (hit && !match_q) begin
				match_q     <= 1'b1;
				match_idx_q <= cnt_q;
			end
			if (!used_q[cnt_q] && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= cnt_q;
			end
		end
	end

	assign slot_sel = match_q ? match_idx_q : free_idx_q;
	assign slot_ip  = pool_q + 32'(slot_sel);
	assign req_ok   = has_sid_q && has_req_q && (sid_q == server_q) && match_q &&
	                  (req_q == slot_ip);
	assign do_alloc = !probe_q && is_disc && !match_q && free_q;

	always_comb begin
		next_kind = REPLY_NAK;
		next_addr = '0;
		if (probe_q) begin
			if (is_disc)     next_kind = REPLY_OFFER;
			else if (is_req) next_kind = REPLY_ACK;
			next_addr = PROBE_ADDRESS;
		end else if (is_disc) begin
			if (match_q || free_q) begin
				next_kind = REPLY_OFFER;
				next_addr = slot_ip;
			end
		end else if (is_req) begin
			if (req_ok) begin
				next_kind = REPLY_ACK;
				next_addr = slot_ip;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.commit && do_alloc) begin
			used_q[free_idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && do_alloc) table_mem[free_idx_q] <= hw_q;
		if (cmd.rd) rd_data_q <= table_mem[cnt_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			reply_kind_q     <= next_kind;
			client_address_q <= next_addr;
		end
	end

	assign out_valid           = out_valid_q;
	assign reply_kind          = reply_kind_q;
	assign client_address      = client_address_q;
	assign lease_time_included = (reply_kind_q != REPLY_NAK);

	assign stat.needs_scan = !probe_q && (is_disc || is_req);
	assign stat.scan_last  = (cnt_q == SLOT_IW'(LEASE_SLOTS - 1));
	assign stat.out_free   = !out_valid_q || out_ready;

endmodule

FILE: src/dhcp_lease_responder.sv
// Sequence: each word is captured; discover and request then scan the lease table slot by slot
//   (read, then compare) before the reply commits; probe and unsupported words skip the scan.
// Flow: one word in flight at a time; the next word is taken while the reply waits.
// Reset (arst_n low, asynchronous): lease table emptied at once through its used flags,
//   registers return to 192.168.1.0 / 192.168.1.1, no reply pending.
module dhcp_lease_responder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [dlr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dlr_pkg::CFG_DATA_W-1:0] cfg_data,
	dlr_msg_if.sink                        msg,
	dlr_reply_if.source                    reply
);
	import dlr_pkg::*;

	// Controller sequences each word: capture, decide whether the table must be
	// searched, walk the slots (read then compare), then commit the reply and
	// any new lease together.
	cmd_t  cmd;
	stat_t stat;
	logic  in_ready;

	dlr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (msg.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Ready only while the controller is idle: one word in flight at a time.
	assign msg.ready = in_ready;

	// Datapath holds the config registers, the lease table memory with its
	// used flags, the scan trackers and the output register.
	dlr_datapath u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.msg_kind            (msg.msg_kind),
		.hw_addr_high        (msg.hw_addr_high),
		.hw_addr_low         (msg.hw_addr_low),
		.has_sid             (msg.has_sid),
		.sid_value           (msg.sid_value),
		.has_req_ip          (msg.has_req_ip),
		.req_ip_value        (msg.req_ip_value),
		.probe_mode          (msg.probe_mode),
		.out_valid           (reply.valid),
		.out_ready           (reply.ready),
		.reply_kind          (reply.reply_kind),
		.client_address      (reply.client_address),
		.lease_time_included (reply.lease_time_included),
		.cmd                 (cmd),
		.stat                (stat)
	);

endmodule

FILE: src/dlr_checker.sv
`include "dhcp_lease_responder_macros.svh"

module dlr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        msg_valid,
	input logic        msg_ready,
	input logic        reply_valid,
	input logic        reply_ready,
	input logic [1:0]  reply_kind,
	input logic [31:0] client_address,
	input logic        lease_time_included
);
	import dlr_pkg::*;

	// Hold a stalled reply word.
	`DLR_ASSERT_NEXT(a_reply_hold, clk, arst_n, reply_valid && !reply_ready, reply_valid && $stable(reply_kind) && $stable(client_address))

	// Lease time goes with every reply but a nak.
	`DLR_ASSERT_IMPLIES(a_lease_flag, clk, arst_n, reply_valid, lease_time_included == (reply_kind != REPLY_NAK))

	// Only offer, ack and nak are produced.
	`DLR_ASSERT_IMPLIES(a_reply_code, clk, arst_n, reply_valid, reply_kind == REPLY_OFFER || reply_kind == REPLY_ACK || reply_kind == REPLY_NAK)

	// One word in flight: drop ready right after an accept.
	`DLR_ASSERT_NEXT(a_one_in_flight, clk, arst_n, msg_valid && msg_ready, !msg_ready)

endmodule

bind dhcp_lease_responder dlr_checker u_dlr_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.msg_valid           (msg.valid),
	.msg_ready           (msg.ready),
	.reply_valid         (reply.valid),
	.reply_ready         (reply.ready),
	.reply_kind          (reply.reply_kind),
	.client_address      (reply.client_address),
	.lease_time_included (reply.lease_time_included)
);
